FILE: rtl/core/size_class_block_allocator_unit_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both expect i_clk and i_rst_n in scope.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SACBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sacba_pkg.sv
`default_nettype none

package sacba_pkg;

    localparam int unsigned CLASS_NUM = 4;
    localparam int unsigned CLS_W     = 2;
    localparam int unsigned POOL_MAX  = 128;
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned SIZE_W    = 21;
    localparam int unsigned REQ_W     = 24;
    localparam int unsigned WORD_W    = 32;

    localparam int unsigned SMALL_COUNT  = 100;
    localparam int unsigned MEDIUM_COUNT = 50;
    localparam int unsigned LARGE_COUNT  = 20;
    localparam int unsigned HUGE_COUNT   = 10;

    localparam logic [SIZE_W-1:0] SIZE_RST [CLASS_NUM] = '{
        SIZE_W'(1024), SIZE_W'(4096), SIZE_W'(16384), SIZE_W'(65536)
    };

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_FREED     = 3'd1,
        ST_CLEARED   = 3'd2,
        ST_NO_FREE   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_BAD_FREE  = 3'd5
    } t_status;

    typedef logic [CLASS_NUM-1:0][SIZE_W-1:0] t_sizes;

    typedef struct packed {
        t_op               op;
        logic [REQ_W-1:0]  req;
        logic [CLS_W-1:0]  fcls;
        logic [IDX_W-1:0]  fidx;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [CLS_W-1:0]  cls;     // granted class, zero otherwise
        logic [IDX_W-1:0]  idx;     // granted index, zero otherwise
        logic [SIZE_W-1:0] gbytes;  // granted size, zero otherwise
        logic [SIZE_W-1:0] delta;   // bytes added to or taken from the total
        logic              add;
        logic              sub;
        logic              clr;
    } t_pool_res;

    function automatic logic [IDX_W:0] pool_len(input logic [CLS_W-1:0] c);
        logic [IDX_W:0] n;
        case (c)
            2'd0:    n = (IDX_W+1)'(SMALL_COUNT);
            2'd1:    n = (IDX_W+1)'(MEDIUM_COUNT);
            2'd2:    n = (IDX_W+1)'(LARGE_COUNT);
            default: n = (IDX_W+1)'(HUGE_COUNT);
        endcase
        return n;
    endfunction

    // blocks that exist in a pool
    function automatic logic [POOL_MAX-1:0] pool_mask(input logic [CLS_W-1:0] c);
        logic [POOL_MAX-1:0] m;
        logic [IDX_W:0]      n;
        n = pool_len(c);
        for (int i = 0; i < POOL_MAX; i++) begin
            m[i] = ((IDX_W+1)'(i) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sacba_cfg.sv
`default_nettype none

module sacba_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [sacba_pkg::CLS_W-1:0]  i_index,
    input  wire logic [sacba_pkg::SIZE_W-1:0] i_data,
    output sacba_pkg::t_sizes                 o_size,
    output logic [sacba_pkg::WORD_W-1:0]      o_cap
);
    import sacba_pkg::*;

    t_sizes            r_size;
    logic [WORD_W-1:0] r_cap;
    logic [WORD_W-1:0] n_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_NUM; c++) begin
                r_size[c] <= SIZE_RST[c];
            end
        end else if (i_we) begin
            r_size[i_index] <= i_data;
        end
    end

    // constant-count products, summed mod 2^32
    always_comb begin
        n_cap = '0;
        for (int c = 0; c < CLASS_NUM; c++) begin
            n_cap = n_cap + WORD_W'(pool_len(CLS_W'(c))) * WORD_W'(r_size[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
    end

    assign o_size = r_size;
    assign o_cap  = r_cap;

endmodule

`default_nettype wire

FILE: rtl/core/sacba_pool.sv
`default_nettype none

`include "size_class_block_allocator_unit_macros.svh"

module sacba_pool (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_vld,
    input  wire sacba_pkg::t_item  i_item,
    input  wire sacba_pkg::t_sizes i_size,
    output sacba_pkg::t_pool_res o_res
);
    import sacba_pkg::*;

    logic [CLASS_NUM-1:0][POOL_MAX-1:0] r_map;
    logic [CLASS_NUM-1:0][POOL_MAX-1:0] n_map;

    logic [CLASS_NUM-1:0] fit;
    logic                 fit_any;
    logic [CLS_W-1:0]     fit_cls;
    logic [POOL_MAX-1:0]  avail;
    logic                 avail_any;
    logic [IDX_W-1:0]     free_idx;
    logic                 free_ok;
    t_pool_res            res;

    // first class that covers the request
    always_comb begin
        fit_cls = '0;
        for (int c = 0; c < CLASS_NUM; c++) begin
            fit[c] = ({{(REQ_W-SIZE_W){1'b0}}, i_size[c]} >= i_item.req);
        end
        for (int c = CLASS_NUM-1; c >= 0; c--) begin
            if (fit[c]) begin
                fit_cls = CLS_W'(c);
            end
        end
        fit_any = |fit;
    end

    // lowest free block of that class
    always_comb begin
        avail    = ~r_map[fit_cls] & pool_mask(fit_cls);
        free_idx = '0;
        for (int i = POOL_MAX-1; i >= 0; i--) begin
            if (avail[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        avail_any = |avail;
    end

    assign free_ok = ({1'b0, i_item.fidx} < pool_len(i_item.fcls))
                     && r_map[i_item.fcls][i_item.fidx];

    always_comb begin
        res   = '0;
        n_map = r_map;
        case (i_item.op)
            OP_ALLOC: begin
                if (!fit_any) begin
                    res.status = ST_TOO_LARGE;
                end else if (!avail_any) begin
                    res.status = ST_NO_FREE;
                end else begin
                    res.status = ST_GRANTED;
                    res.cls    = fit_cls;
                    res.idx    = free_idx;
                    res.gbytes = i_size[fit_cls];
                    res.delta  = i_size[fit_cls];
                    res.add    = 1'b1;
                    n_map[fit_cls][free_idx] = 1'b1;
                end
            end
            OP_FREE: begin
                if (free_ok) begin
                    res.status = ST_FREED;
                    res.delta  = i_size[i_item.fcls];
                    res.sub    = 1'b1;
                    n_map[i_item.fcls][i_item.fidx] = 1'b0;
                end else begin
                    res.status = ST_BAD_FREE;
                end
            end
            OP_CLEAR: begin
                res.status = ST_CLEARED;
                res.clr    = 1'b1;
                n_map      = '0;
            end
            default: begin
                res.status = ST_BAD_FREE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_vld) begin
            r_map <= n_map;
        end
    end

    assign o_res = res;

    `SACBA_ASSERT_NXT(a_grant_marks, i_vld && res.add,
        r_map[$past(res.cls)][$past(res.idx)], "granted block not marked")
    `SACBA_ASSERT_NXT(a_clear_empties, i_vld && res.clr,
        r_map == '0, "pools not empty after clear")
    `SACBA_ASSERT_NXT(a_bad_free_keeps, i_vld && i_item.op == OP_FREE && !free_ok,
        $stable(r_map), "bad free changed a pool")

endmodule

`default_nettype wire

FILE: rtl/core/size_class_block_allocator_unit.sv
// Size-class block allocator: four fixed-block pools with in-use bitmaps.
// A request beat is registered in the input stage and its result beat, o_done high,
// in the result stage. Throughput: one request per cycle, busy stays low.
// Opcode 3 is taken and dropped. Results cannot be stalled by the receiver.
// Reset (i_rst_n low, synchronous): pools empty, totals zero, block sizes at
// defaults; busy is high for one cycle after reset.
`default_nettype none

`include "size_class_block_allocator_unit_macros.svh"

module size_class_block_allocator_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [sacba_pkg::REQ_W-1:0]  i_request_bytes,
    input  wire logic [sacba_pkg::CLS_W-1:0]  i_free_class,
    input  wire logic [sacba_pkg::IDX_W-1:0]  i_free_index,
    // block size registers
    input  wire logic                         i_cfg_we,
    input  wire logic [sacba_pkg::CLS_W-1:0]  i_cfg_index,
    input  wire logic [sacba_pkg::SIZE_W-1:0] i_cfg_data,
    // result channel
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic [sacba_pkg::CLS_W-1:0]       o_grant_class,
    output logic [sacba_pkg::IDX_W-1:0]       o_grant_index,
    output logic [sacba_pkg::SIZE_W-1:0]      o_grant_bytes,
    output logic [sacba_pkg::WORD_W-1:0]      o_used_bytes,
    output logic [sacba_pkg::WORD_W-1:0]      o_alloc_count,
    output logic [sacba_pkg::WORD_W-1:0]      o_free_count,
    output logic [sacba_pkg::WORD_W-1:0]      o_capacity_bytes
);
    import sacba_pkg::*;

    logic              r_busy;
    logic              accept;

    // input stage
    logic              r_vld;
    t_item             r_item;

    // result stage
    logic              r_done;
    t_status           r_status;
    logic [CLS_W-1:0]  r_gcls;
    logic [IDX_W-1:0]  r_gidx;
    logic [SIZE_W-1:0] r_gbytes;

    // running totals
    logic [WORD_W-1:0] r_used;
    logic [WORD_W-1:0] n_used;
    logic [WORD_W-1:0] r_alloc;
    logic [WORD_W-1:0] r_free;

    t_sizes            size;
    logic [WORD_W-1:0] cap;
    t_pool_res         res;

    // busy while in reset and in the cycle that follows it
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy && (t_op'(i_opcode) != OP_RSVD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op   <= t_op'(i_opcode);
            r_item.req  <= i_request_bytes;
            r_item.fcls <= i_free_class;
            r_item.fidx <= i_free_index;
        end
    end

    sacba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_size  (size),
        .o_cap   (cap)
    );

    // bitmaps update at the same edge as the result stage, so the next
    // request in the input stage already sees this one's outcome
    sacba_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_item  (r_item),
        .i_size  (size),
        .o_res   (res)
    );

    always_comb begin
        n_used = r_used;
        if (res.clr) begin
            n_used = '0;
        end else if (res.add) begin
            n_used = r_used + WORD_W'(res.delta);
        end else if (res.sub) begin
            n_used = r_used - WORD_W'(res.delta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_used  <= '0;
            r_alloc <= '0;
            r_free  <= '0;
        end else begin
            r_done <= r_vld;
            if (r_vld) begin
                r_used <= n_used;
                if (r_item.op == OP_ALLOC) begin
                    r_alloc <= r_alloc + 1'b1;
                end
                if (r_item.op == OP_FREE) begin
                    r_free <= r_free + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_status <= res.status;
            r_gcls   <= res.cls;
            r_gidx   <= res.idx;
            r_gbytes <= res.gbytes;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_grant_class    = r_gcls;
    assign o_grant_index    = r_gidx;
    assign o_grant_bytes    = r_gbytes;
    assign o_used_bytes     = r_used;
    assign o_alloc_count    = r_alloc;
    assign o_free_count     = r_free;
    assign o_capacity_bytes = cap;

    `SACBA_ASSERT_IMP(a_nogrant_zero, o_done && r_status != ST_GRANTED,
        r_gcls == '0 && r_gidx == '0 && r_gbytes == '0, "grant fields set without a grant")
    `SACBA_ASSERT_IMP(a_clear_used, o_done && r_status == ST_CLEARED,
        r_used == '0, "used bytes nonzero after clear")
    `SACBA_ASSERT_IMP(a_alloc_count,
        o_done && (r_status == ST_GRANTED || r_status == ST_NO_FREE || r_status == ST_TOO_LARGE),
        r_alloc == $past(r_alloc) + 1'b1, "alloc count did not advance")

endmodule

`default_nettype wire

FILE: verif/alloc_checker.sv
`default_nettype none

module alloc_checker
    import sacba_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [REQ_W-1:0]    i_request_bytes,
    input  wire logic [CLS_W-1:0]    i_free_class,
    input  wire logic [IDX_W-1:0]    i_free_index,
    input  wire logic                i_cfg_we,
    input  wire logic [CLS_W-1:0]    i_cfg_index,
    input  wire logic [SIZE_W-1:0]   i_cfg_data,
    input  wire logic                o_done,
    input  wire logic [2:0]          o_status,
    input  wire logic [CLS_W-1:0]    o_grant_class,
    input  wire logic [IDX_W-1:0]    o_grant_index,
    input  wire logic [SIZE_W-1:0]   o_grant_bytes,
    input  wire logic [WORD_W-1:0]   o_used_bytes,
    input  wire logic [WORD_W-1:0]   o_alloc_count,
    input  wire logic [WORD_W-1:0]   o_free_count,
    input  wire logic [WORD_W-1:0]   o_capacity_bytes,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int unsigned POOL_DEPTH [CLASS_NUM] = '{
        SMALL_COUNT, MEDIUM_COUNT, LARGE_COUNT, HUGE_COUNT
    };

    typedef struct {
        t_status            status;
        logic [CLS_W-1:0]   cls;
        logic [IDX_W-1:0]   idx;
        logic [SIZE_W-1:0]  gbytes;
        logic [WORD_W-1:0]  used;
        logic [WORD_W-1:0]  allocs;
        logic [WORD_W-1:0]  frees;
        logic [WORD_W-1:0]  cap;
    } t_alloc_reply;

    logic [SIZE_W-1:0]   class_bytes [CLASS_NUM];
    logic [POOL_MAX-1:0] in_use     [CLASS_NUM];
    logic [WORD_W-1:0]   used_total;
    logic [WORD_W-1:0]   alloc_total;
    logic [WORD_W-1:0]   free_total;
    t_alloc_reply        pending_replies [$];

    function automatic logic [WORD_W-1:0] pool_capacity();
        logic [WORD_W-1:0] sum;
        sum = '0;
        for (int c = 0; c < CLASS_NUM; c++) begin
            sum += WORD_W'(POOL_DEPTH[c]) * WORD_W'(class_bytes[c]);
        end
        return sum;
    endfunction

    // updates the pool state for one request beat and gives its reply
    task automatic model_request(input t_op op, input logic [REQ_W-1:0] req,
                                 input logic [CLS_W-1:0] fcls,
                                 input logic [IDX_W-1:0] fidx,
                                 output t_alloc_reply r);
        int fit;
        logic granted;
        fit     = CLASS_NUM;
        granted = 1'b0;
        r.status = ST_GRANTED;
        r.cls    = '0;
        r.idx    = '0;
        r.gbytes = '0;
        case (op)
            OP_ALLOC: begin
                alloc_total += 1;
                // first class that fits, in class order, sizes need not ascend
                for (int c = CLASS_NUM - 1; c >= 0; c--) begin
                    if (32'(req) <= 32'(class_bytes[c])) fit = c;
                end
                if (fit == CLASS_NUM) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    r.status = ST_NO_FREE;
                    for (int i = 0; i < POOL_DEPTH[fit]; i++) begin
                        if (!granted && !in_use[fit][i]) begin
                            granted        = 1'b1;
                            in_use[fit][i] = 1'b1;
                            used_total    += WORD_W'(class_bytes[fit]);
                            r.status       = ST_GRANTED;
                            r.cls          = CLS_W'(fit);
                            r.idx          = IDX_W'(i);
                            r.gbytes       = class_bytes[fit];
                        end
                    end
                end
            end
            OP_FREE: begin
                free_total += 1;
                if (32'(fidx) < POOL_DEPTH[fcls] && in_use[fcls][fidx]) begin
                    in_use[fcls][fidx] = 1'b0;
                    // current register value, even if changed since the grant
                    used_total -= WORD_W'(class_bytes[fcls]);
                    r.status    = ST_FREED;
                end else begin
                    r.status = ST_BAD_FREE;
                end
            end
            default: begin
                for (int c = 0; c < CLASS_NUM; c++) in_use[c] = '0;
                used_total = '0;
                r.status   = ST_CLEARED;
            end
        endcase
        r.used   = used_total;
        r.allocs = alloc_total;
        r.frees  = free_total;
        r.cap    = pool_capacity();
    endtask

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_alloc_reply want;
        t_alloc_reply fresh;
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_NUM; c++) begin
                class_bytes[c] = SIZE_RST[c];
                in_use[c]      = '0;
            end
            used_total  = '0;
            alloc_total = '0;
            free_total  = '0;
            pending_replies.delete();
        end else begin
            // result beats belong to older requests, so check them first
            if (o_done) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t unexpected result beat: expected none actual status %0d",
                             $time, o_status);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(o_status));
                    check_field("grant_class", WORD_W'(want.cls), WORD_W'(o_grant_class));
                    check_field("grant_index", WORD_W'(want.idx), WORD_W'(o_grant_index));
                    check_field("grant_bytes", WORD_W'(want.gbytes), WORD_W'(o_grant_bytes));
                    check_field("used_bytes", want.used, o_used_bytes);
                    check_field("alloc_count", want.allocs, o_alloc_count);
                    check_field("free_count", want.frees, o_free_count);
                    check_field("capacity_bytes", want.cap, o_capacity_bytes);
                end
            end
            if (i_cfg_we) class_bytes[i_cfg_index] = i_cfg_data;
            if (start && !busy && t_op'(i_opcode) != OP_RSVD) begin
                model_request(t_op'(i_opcode), i_request_bytes, i_free_class,
                              i_free_index, fresh);
                pending_replies.push_back(fresh);
            end
        end
        outstanding = pending_replies.size();
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
    import sacba_pkg::*;

    // a request beat passes the input and result stages before its result beat is seen
    localparam int DRAIN_CYCLES = 4;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BEATS  = 75;

    localparam int unsigned POOL_DEPTH [CLASS_NUM] = '{
        SMALL_COUNT, MEDIUM_COUNT, LARGE_COUNT, HUGE_COUNT
    };

    // size class codes; register i holds the block size of class i
    typedef enum logic [CLS_W-1:0] {
        CLS_SMALL  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LARGE  = 2'd2,
        CLS_HUGE   = 2'd3
    } t_size_class;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_opcode;
    logic [REQ_W-1:0]    i_request_bytes;
    logic [CLS_W-1:0]    i_free_class;
    logic [IDX_W-1:0]    i_free_index;
    logic                i_cfg_we;
    logic [CLS_W-1:0]    i_cfg_index;
    logic [SIZE_W-1:0]   i_cfg_data;
    logic                o_done;
    logic [2:0]          o_status;
    logic [CLS_W-1:0]    o_grant_class;
    logic [IDX_W-1:0]    o_grant_index;
    logic [SIZE_W-1:0]   o_grant_bytes;
    logic [WORD_W-1:0]   o_used_bytes;
    logic [WORD_W-1:0]   o_alloc_count;
    logic [WORD_W-1:0]   o_free_count;
    logic [WORD_W-1:0]   o_capacity_bytes;

    int                  mismatches;
    int                  outstanding;
    int                  cycle_count;
    logic                busy_seen;
    // block sizes last written, used only to aim request sizes at class edges
    logic [SIZE_W-1:0]   cur_sizes [CLASS_NUM];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    size_class_block_allocator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_request_bytes  (i_request_bytes),
        .i_free_class     (i_free_class),
        .i_free_index     (i_free_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_grant_class    (o_grant_class),
        .o_grant_index    (o_grant_index),
        .o_grant_bytes    (o_grant_bytes),
        .o_used_bytes     (o_used_bytes),
        .o_alloc_count    (o_alloc_count),
        .o_free_count     (o_free_count),
        .o_capacity_bytes (o_capacity_bytes)
    );

    alloc_checker alloc_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_request_bytes  (i_request_bytes),
        .i_free_class     (i_free_class),
        .i_free_index     (i_free_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_grant_class    (o_grant_class),
        .o_grant_index    (o_grant_index),
        .o_grant_bytes    (o_grant_bytes),
        .o_used_bytes     (o_used_bytes),
        .o_alloc_count    (o_alloc_count),
        .o_free_count     (o_free_count),
        .o_capacity_bytes (o_capacity_bytes),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // busy only moves at the rising edge; the copy taken mid-cycle is the
    // value the block sees at the next edge, with no race against its update
    always @(negedge i_clk) begin
        busy_seen <= busy;
    end

    // one request beat; returns at the edge that took it, maybe after a gap
    task automatic send_beat(input t_op op, input logic [REQ_W-1:0] req,
                             input logic [CLS_W-1:0] fcls,
                             input logic [IDX_W-1:0] fidx, input int idle_pct);
        start           <= 1'b1;
        i_opcode        <= op;
        i_request_bytes <= req;
        i_free_class    <= fcls;
        i_free_index    <= fidx;
        do @(posedge i_clk); while (busy_seen);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // waits out every expected result beat plus the pipeline depth, so that
    // a dropped opcode 3 beat is gone too; caller has lowered start
    task automatic wait_idle();
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                             input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3);
        logic [SIZE_W-1:0] vals [CLASS_NUM];
        vals = '{s0, s1, s2, s3};
        for (int c = 0; c < CLASS_NUM; c++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_size_class'(c);
            i_cfg_data  <= vals[c];
            cur_sizes[c] = vals[c];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] rand_size();
        if ($urandom_range(7) == 0) return '0;
        return SIZE_W'($urandom_range(1, 1048576));
    endfunction

    // sizes mostly on or next to a class boundary, so every class and the
    // too-large case get hit; a tenth is raw 24-bit noise
    function automatic logic [REQ_W-1:0] pick_request();
        int k;
        int c;
        logic [REQ_W-1:0] sz;
        k  = $urandom_range(99);
        c  = $urandom_range(CLASS_NUM - 1);
        sz = REQ_W'(cur_sizes[c]);
        if (k < 10) return REQ_W'($urandom);
        if (k < 30) return sz;
        if (k < 45) return sz + 1'b1;
        if (k < 60) return (sz == 0) ? sz : sz - 1'b1;
        if (k < 70) return '0;
        return REQ_W'($urandom_range(0, sz));
    endfunction

    // low indices are the ones granted first, so aim most frees there
    function automatic logic [IDX_W-1:0] pick_index(input logic [CLS_W-1:0] fcls);
        int k;
        int depth;
        k     = $urandom_range(99);
        depth = POOL_DEPTH[fcls];
        if (k < 50) return IDX_W'($urandom_range(0, depth - 1));
        if (k < 80) return IDX_W'($urandom_range(0, (depth < 16 ? depth : 16) - 1));
        return IDX_W'($urandom_range(depth, POOL_MAX - 1));
    endfunction

    // random traffic: mostly allocates and frees so the pools fill up and
    // run dry; clears are rare; opcode 3 beats are dropped and not counted
    task automatic run_traffic(input int beats, input int idle_pct);
        int n;
        int k;
        t_op op;
        logic [CLS_W-1:0] fcls;
        n = 0;
        while (n < beats) begin
            // hold off once per phase, and now and then, until all results are in
            if (n == beats / 2 || $urandom_range(99) < 2) begin
                start <= 1'b0;
                wait_idle();
            end
            k    = $urandom_range(99);
            op   = (k < 55) ? OP_ALLOC : (k < 90) ? OP_FREE : (k < 96) ? OP_CLEAR : OP_RSVD;
            fcls = CLS_W'($urandom_range(CLASS_NUM - 1));
            case (op)
                OP_ALLOC: send_beat(op, pick_request(), fcls, IDX_W'($urandom), idle_pct);
                OP_FREE:  send_beat(op, REQ_W'($urandom), fcls, pick_index(fcls), idle_pct);
                default:  send_beat(op, REQ_W'($urandom), fcls, IDX_W'($urandom), idle_pct);
            endcase
            if (op != OP_RSVD) n++;
        end
    endtask

    task automatic config_phase(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                                input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
                                input int idle_pct);
        // registers only change with the block idle
        start <= 1'b0;
        wait_idle();
        set_sizes(s0, s1, s2, s3);
        run_traffic(PHASE_BEATS, idle_pct);
    endtask

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_opcode        <= OP_ALLOC;
        i_request_bytes <= '0;
        i_free_class    <= '0;
        i_free_index    <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        busy_seen       <= 1'b1;
        for (int c = 0; c < CLASS_NUM; c++) cur_sizes[c] = SIZE_RST[c];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on reset sizes 1024/4096/16384/65536
        send_beat(OP_ALLOC, 24'd0, CLS_SMALL, 7'd0, 0);         // zero-byte request
        send_beat(OP_ALLOC, 24'd1024, CLS_SMALL, 7'd0, 0);      // exact fit, class 0
        send_beat(OP_ALLOC, 24'd1025, CLS_SMALL, 7'd0, 0);      // just over, class 1
        send_beat(OP_ALLOC, 24'd16385, CLS_SMALL, 7'd0, 0);     // lands in huge
        send_beat(OP_ALLOC, 24'd65537, CLS_SMALL, 7'd0, 0);     // too large
        send_beat(OP_ALLOC, 24'hFFFFFF, CLS_HUGE, 7'h7F, 0);    // widest request
        send_beat(OP_FREE, 24'd0, CLS_SMALL, 7'd1, 0);          // good free
        send_beat(OP_FREE, 24'd0, CLS_SMALL, 7'd1, 0);          // same block again
        send_beat(OP_FREE, 24'd0, CLS_SMALL, 7'h7F, 0);         // index past the pool
        send_beat(OP_FREE, 24'd0, CLS_HUGE, 7'd10, 0);          // one past huge pool
        send_beat(OP_RSVD, 24'hFFFFFF, CLS_HUGE, 7'h7F, 0);     // dropped, no result
        send_beat(OP_CLEAR, 24'd0, CLS_SMALL, 7'd0, 0);
        // fill the huge pool, then one more finds it full
        for (int i = 0; i <= HUGE_COUNT; i++) begin
            send_beat(OP_ALLOC, 24'd65536, CLS_SMALL, 7'd0, 0);
        end
        send_beat(OP_FREE, 24'd0, CLS_HUGE, 7'(HUGE_COUNT - 1), 0);  // last valid index
        send_beat(OP_FREE, 24'd0, CLS_LARGE, 7'd0, 0);               // never granted

        // sender idles 7 in 100 beats
        config_phase(21'd16, 21'd64, 21'd256, 21'd1024, 7);
        config_phase(21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576, 7);
        // sender idles 52 in 100; sizes out of order, then a zero-size class
        config_phase(21'd65536, 21'd4096, 21'd256, 21'd1, 52);
        config_phase(21'd0, 21'd1, 21'd1048575, 21'd1048576, 52);
        // no idling
        config_phase(21'd1, 21'd1, 21'd1, 21'd1, 0);
        config_phase(rand_size(), rand_size(), rand_size(), rand_size(), 0);

        start <= 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
